// File: hdl/mtlb_pkg.sv
// Shared types and constants for the joint TLB.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mtlb_pkg;

   // Number of entries; a power of two from 2 to 32.
   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);

   localparam int REQ_W = 144;   // 142 payload bits padded to whole bytes
   localparam int RSP_W = 168;

   localparam logic [7:0]  ASID_MASK = 8'hFF;
   localparam logic [23:0] PFN_FIELD = 24'hFF_FFFF;

   typedef enum logic [2:0] {
      CMD_TRANSLATE   = 3'd0,
      CMD_WRITE_INDEX = 3'd1,
      CMD_WRITE_RAND  = 3'd2,
      CMD_PROBE       = 3'd3,
      CMD_READ        = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_MISS     = 2'd1,
      ST_INVALID  = 2'd2,
      ST_MODIFIED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_PAGE_SHIFT = 2'd0,
      CSR_PHYS_MASK  = 2'd1,
      CSR_WIRED      = 2'd2
   } csr_type;

   // Controller to datapath strobes.
   typedef struct packed {
      logic capture;   // input transfer: latch the item, step the random counter
      logic look;      // compare all entries, perform a pending write
      logic eval;      // read the selected entry and load the result register
   } dp_cmd_type;

endpackage
`default_nettype wire

// File: hdl/mtlb_ctrl.sv
// Sequencing state machine for the joint TLB.
// Depends on mtlb_pkg; drives the datapath through dp_cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module mtlb_ctrl
   import mtlb_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output dp_cmd_type dp_cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_EVAL = 4'b0100,
      S_SEND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_LOOK;
         S_LOOK: state_in = S_EVAL;
         S_EVAL: state_in = S_SEND;
         S_SEND: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready     = (state_ff == S_IDLE);
   assign rsp_tvalid     = (state_ff == S_SEND);
   assign dp_cmd.capture = req_tvalid && (state_ff == S_IDLE);
   assign dp_cmd.look    = (state_ff == S_LOOK);
   assign dp_cmd.eval    = (state_ff == S_EVAL);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input and result sides both open");
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |=> dp_cmd.look) else $error("accepted item not compared");
   a_eval_send: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.eval |=> rsp_tvalid) else $error("result not presented after eval");
   a_send_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready) else $error("no return to idle");

endmodule
`default_nettype wire

// File: hdl/mtlb_dp.sv
// Entry store, parallel match, write and result formatting for the joint TLB.
// Depends on mtlb_pkg; sequenced by mtlb_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module mtlb_dp
   import mtlb_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire dp_cmd_type  dp_cmd,
   input  wire [2:0]        req_cmd,
   input  wire [REQ_W-1:0]  req_data,
   input  wire              csr_we,
   input  wire [1:0]        csr_index,
   input  wire [31:0]       csr_wdata,
   output logic [RSP_W-1:0] rsp_data
);

   // Configuration.
   logic [3:0]  shift_cfg_ff;
   logic [31:0] pmask_cfg_ff;
   logic [4:0]  wired_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_cfg_ff <= 4'd12;
         pmask_cfg_ff <= 32'hFFFF_FFFF;
         wired_cfg_ff <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAGE_SHIFT: shift_cfg_ff <= csr_wdata[3:0];
            CSR_PHYS_MASK:  pmask_cfg_ff <= csr_wdata;
            CSR_WIRED:      wired_cfg_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic [3:0]  shift;
   logic [31:0] pair_mask;
   always_comb begin
      if (shift_cfg_ff < 4'd10)      shift = 4'd10;
      else if (shift_cfg_ff > 4'd12) shift = 4'd12;
      else                           shift = shift_cfg_ff;
      pair_mask = ~(32'hFFFF_FFFF << (shift + 4'd1));
   end

   // Latched item.
   logic [2:0]       q_cmd_ff;
   logic [31:0]      q_va_ff, q_pm_ff, q_lo0_ff, q_lo1_ff;
   logic [7:0]       q_asid_ff;
   logic             q_wr_ff;
   logic [IDX_W-1:0] q_idx_ff, w_idx_ff;
   logic [IDX_W-1:0] rnd_ff, rnd_in;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   always_comb begin
      if ({1'b0, rnd_ff} <= (IDX_W + 1)'(wired_cfg_ff)) rnd_in = LAST;
      else                                              rnd_in = rnd_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rnd_ff <= LAST;
      else if (dp_cmd.capture) rnd_ff <= rnd_in;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         q_cmd_ff  <= req_cmd;
         q_va_ff   <= req_data[31:0];
         q_asid_ff <= req_data[39:32] & ASID_MASK;
         q_wr_ff   <= req_data[40];
         q_idx_ff  <= IDX_W'(req_data[45:41]);
         q_pm_ff   <= req_data[77:46];
         q_lo0_ff  <= req_data[109:78];
         q_lo1_ff  <= req_data[141:110];
         // A random write uses the counter value from before this item.
         w_idx_ff  <= (req_cmd == CMD_WRITE_RAND) ? rnd_ff : IDX_W'(req_data[45:41]);
      end
   end

   // Entry store. Flags: G, V0, D0, C0(3), V1, D1, C1(3) from bit 0 up.
   logic [31:0] vpn2_ff  [ENTRIES];
   logic [7:0]  asid_ff  [ENTRIES];
   logic [31:0] mask_ff  [ENTRIES];
   logic [10:0] flags_ff [ENTRIES];
   logic [35:0] pfn0_ff  [ENTRIES];
   logic [35:0] pfn1_ff  [ENTRIES];

   logic        do_write;
   logic [31:0] pm_shifted;
   logic [35:0] new_pfn0, new_pfn1;
   always_comb begin
      do_write   = dp_cmd.look &&
                   (q_cmd_ff == CMD_WRITE_INDEX || q_cmd_ff == CMD_WRITE_RAND);
      pm_shifted = q_pm_ff >> (shift + 4'd1);
      new_pfn0   = 36'(q_lo0_ff[29:6] & PFN_FIELD & ~pm_shifted[23:0]) << shift;
      new_pfn1   = 36'(q_lo1_ff[29:6] & PFN_FIELD & ~pm_shifted[23:0]) << shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            vpn2_ff[i]  <= '0;
            asid_ff[i]  <= '0;
            mask_ff[i]  <= '0;
            flags_ff[i] <= '0;
            pfn0_ff[i]  <= '0;
            pfn1_ff[i]  <= '0;
         end
      end else if (do_write) begin
         vpn2_ff[w_idx_ff]  <= q_va_ff & ~pair_mask;
         asid_ff[w_idx_ff]  <= q_asid_ff;
         mask_ff[w_idx_ff]  <= q_pm_ff;
         flags_ff[w_idx_ff] <= {q_lo1_ff[5:1], q_lo0_ff[5:1], q_lo0_ff[0] & q_lo1_ff[0]};
         pfn0_ff[w_idx_ff]  <= new_pfn0;
         pfn1_ff[w_idx_ff]  <= new_pfn1;
      end
   end

   // Parallel compare; the lowest matching index wins.
   logic [ENTRIES-1:0] match;
   logic [IDX_W-1:0]   first;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               any_ff;

   always_comb begin
      first = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (flags_ff[i][0] || asid_ff[i] == q_asid_ff) &&
                    (((vpn2_ff[i] ^ q_va_ff) & ~(mask_ff[i] | pair_mask)) == 32'd0);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) first = IDX_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.look) begin
         hit_idx_ff <= first;
         any_ff     <= |match;
      end
   end

   // Result formatting from the selected entry.
   logic [IDX_W-1:0] sel;
   logic [31:0]      em, pa;
   logic [10:0]      f;
   logic             odd, v, d;
   logic [35:0]      pfn, pfn0_sh, pfn1_sh;
   logic [1:0]       st_in;
   logic [31:0]      pa_in, hi_in, pm_in, lo0_in, lo1_in;
   logic             g_in;
   logic [4:0]       hit_in;
   logic [RSP_W-1:0] rsp_data_ff;

   always_comb begin
      sel     = (q_cmd_ff == CMD_READ) ? q_idx_ff : hit_idx_ff;
      em      = mask_ff[sel] | pair_mask;
      f       = flags_ff[sel];
      odd     = |(q_va_ff & em & ~(em >> 1));
      v       = odd ? f[6] : f[1];
      d       = odd ? f[7] : f[2];
      pfn     = odd ? pfn1_ff[sel] : pfn0_ff[sel];
      pa      = pfn[31:0] | (q_va_ff & (em >> 1));
      pfn0_sh = pfn0_ff[sel] >> shift;
      pfn1_sh = pfn1_ff[sel] >> shift;

      st_in  = ST_HIT;
      pa_in  = '0;
      g_in   = 1'b0;
      hit_in = '0;
      hi_in  = '0;
      pm_in  = '0;
      lo0_in = '0;
      lo1_in = '0;
      case (q_cmd_ff)
         CMD_TRANSLATE: begin
            if (!any_ff) begin
               st_in = ST_MISS;
            end else begin
               g_in = f[0];
               if (!v)                   st_in = ST_INVALID;
               else if (!q_wr_ff || d) begin
                  st_in = ST_HIT;
                  pa_in = pa & pmask_cfg_ff;
               end else                  st_in = ST_MODIFIED;
            end
         end
         CMD_PROBE: begin
            if (any_ff) hit_in = 5'(hit_idx_ff);
            else        st_in  = ST_MISS;
         end
         CMD_READ: begin
            hi_in  = vpn2_ff[sel] | {24'd0, asid_ff[sel]};
            pm_in  = mask_ff[sel];
            lo0_in = {2'b00, pfn0_sh[23:0] & PFN_FIELD, f[5:1], f[0]};
            lo1_in = {2'b00, pfn1_sh[23:0] & PFN_FIELD, f[10:6], f[0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.eval) begin
         rsp_data_ff <= {lo1_in, lo0_in, pm_in, hi_in, hit_in, g_in, pa_in, st_in};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// File: hdl/mips_tlb_translate_and_maintain_top.sv
// Top level of the joint TLB: controller plus datapath.
// Depends on mtlb_pkg, mtlb_ctrl and mtlb_dp.
//
//  Channel  Direction  Payload
//  req_     in         tuser: command; tdata: address, asid, store flag, index,
//                      page mask, even and odd entry words
//  rsp_     out        tdata: status, physical address, global, probe index,
//                      read entry hi, page mask, even and odd words
//  csr_     in         write enable, register index, 32-bit data
//
// Each item is latched, compared against all entries, then read and formatted
// before its result is shown; the next item is taken in the cycle after
// the result transfer, so items are handled one at a time.
// Synchronous active-high reset clears all entries and sets the random counter to the last index.
// A stalled result holds the block; no item is taken until it transfers.
`timescale 1ns / 1ps
`default_nettype none
module mips_tlb_translate_and_maintain_top
   import mtlb_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire [2:0]        req_tuser,   // command
   // virtual_address, asid, is_write, entry_index, pg_mask,
   // entry_lo_even, entry_lo_odd, two zero pad bits
   input  wire [REQ_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   // status, phys_addr, is_global, hit_index, read_entry_hi,
   // read_pg_mask, read_lo_even, read_lo_odd
   output logic [RSP_W-1:0] rsp_tdata,
   input  wire              csr_we,
   input  wire [1:0]        csr_index,
   input  wire [31:0]       csr_wdata
);

   dp_cmd_type dp_cmd;

   mtlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   mtlb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_cmd   (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking bench for the joint TLB top level: a queued driver, a result monitor
// and a behavioral predictor of the entry table. Depends on mtlb_pkg and the RTL.
`timescale 1ns / 1ps
module tb
   import mtlb_pkg::*;
();

   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] va;
      logic [7:0]  asid;
      logic        wr;
      logic [4:0]  idx;
      logic [31:0] pm;
      logic [31:0] lo0;
      logic [31:0] lo1;
   } tlb_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] pa;
      logic        glob;
      logic [4:0]  hidx;
      logic [31:0] ehi;
      logic [31:0] rpm;
      logic [31:0] rlo0;
      logic [31:0] rlo1;
   } tlb_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire  req_tready;
   logic [2:0] req_tuser = '0;
   logic [REQ_W-1:0] req_tdata = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire  [RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   mips_tlb_translate_and_maintain_top dut (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic [31:0] m_vpn2 [ENTRIES];
   logic [7:0]  m_asid [ENTRIES];
   logic [31:0] m_mask [ENTRIES];
   logic [10:0] m_flags [ENTRIES];
   logic [35:0] m_pfn0 [ENTRIES];
   logic [35:0] m_pfn1 [ENTRIES];
   int unsigned m_rand;
   logic [3:0]  cfg_shift;
   logic [31:0] cfg_pmask;
   logic [4:0]  cfg_wired;

   tlb_req_type pending_q[$];
   tlb_rsp_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 0;

   function automatic int shift_now();
      if (cfg_shift < 10) return 10;
      if (cfg_shift > 12) return 12;
      return cfg_shift;
   endfunction

   function automatic logic [31:0] pair_mask();
      return (32'd1 << (shift_now() + 1)) - 32'd1;
   endfunction

   function automatic bit entry_hit(int i, logic [31:0] va, logic [7:0] asid,
                                    output logic [31:0] m);
      m = m_mask[i] | pair_mask();
      return (m_flags[i][0] || m_asid[i] == asid) && ((m_vpn2[i] & ~m) == (va & ~m));
   endfunction

   task automatic fill_entry(int i, tlb_req_type r);
      int s;
      logic [31:0] pmsh;
      s = shift_now();
      pmsh = r.pm >> (s + 1);
      m_vpn2[i] = r.va & ~pair_mask();
      m_asid[i] = r.asid;
      m_mask[i] = r.pm;
      m_flags[i] = {r.lo1[5:1], r.lo0[5:1], r.lo0[0] & r.lo1[0]};
      m_pfn0[i] = 36'({8'd0, r.lo0[29:6] & ~pmsh[23:0]}) << s;
      m_pfn1[i] = 36'({8'd0, r.lo1[29:6] & ~pmsh[23:0]}) << s;
   endtask

   function automatic logic [31:0] rebuild_lo(logic [4:0] half, logic g, logic [35:0] pfn);
      logic [35:0] t;
      t = pfn >> shift_now();
      return {2'b00, t[23:0], half, g};
   endfunction

   task automatic predict_tlb(tlb_req_type r);
      tlb_rsp_type e;
      logic [31:0] m;
      logic [35:0] pfn;
      logic [31:0] pa;
      bit odd, v, d;
      int i;
      e = '{default: '0};
      case (r.cmd)
         CMD_TRANSLATE: begin
            e.status = ST_MISS;
            for (i = 0; i < ENTRIES; i++) begin
               if (entry_hit(i, r.va, r.asid, m)) begin
                  odd = (r.va & m & ~(m >> 1)) != 0;
                  v = odd ? m_flags[i][6] : m_flags[i][1];
                  d = odd ? m_flags[i][7] : m_flags[i][2];
                  e.glob = m_flags[i][0];
                  if (!v) begin
                     e.status = ST_INVALID;
                  end else if (!r.wr || d) begin
                     pfn = odd ? m_pfn1[i] : m_pfn0[i];
                     pa = pfn[31:0] | (r.va & (m >> 1));
                     e.status = ST_HIT;
                     e.pa = pa & cfg_pmask;
                  end else begin
                     e.status = ST_MODIFIED;
                  end
                  break;
               end
            end
         end
         CMD_WRITE_INDEX: fill_entry(r.idx, r);
         CMD_WRITE_RAND: fill_entry(m_rand, r);
         CMD_PROBE: begin
            e.status = ST_MISS;
            for (i = 0; i < ENTRIES; i++) begin
               if (entry_hit(i, r.va, r.asid, m)) begin
                  e.status = ST_HIT;
                  e.hidx = 5'(i);
                  break;
               end
            end
         end
         CMD_READ: begin
            e.ehi = m_vpn2[r.idx] | {24'd0, m_asid[r.idx]};
            e.rpm = m_mask[r.idx];
            e.rlo0 = rebuild_lo(m_flags[r.idx][5:1], m_flags[r.idx][0], m_pfn0[r.idx]);
            e.rlo1 = rebuild_lo(m_flags[r.idx][10:6], m_flags[r.idx][0], m_pfn1[r.idx]);
         end
         default: ;
      endcase
      if (m_rand <= cfg_wired || m_rand > ENTRIES - 1) m_rand = ENTRIES - 1;
      else m_rand--;
      expected_q.push_back(e);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   // Driver: a transfer pops the head; a waiting item is held until it transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_tlb(pending_q.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_q[0].cmd;
               req_tdata <= {2'b00, pending_q[0].lo1, pending_q[0].lo0, pending_q[0].pm,
                             pending_q[0].idx, pending_q[0].wr, pending_q[0].asid,
                             pending_q[0].va};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      tlb_rsp_type e, g;
      if (!reset) begin
         rsp_tready <= calm || $urandom_range(99) >= 30;
         if (rsp_tvalid && rsp_tready) begin
            {g.rlo1, g.rlo0, g.rpm, g.ehi, g.hidx, g.glob, g.pa, g.status} = rsp_tdata;
            if (expected_q.size() == 0) begin
               report("unexpected transfer", 0, 0);
            end else begin
               e = expected_q.pop_front();
               if (g.status !== e.status) report("status", g.status, e.status);
               if (g.pa !== e.pa) report("phys_addr", g.pa, e.pa);
               if (g.glob !== e.glob) report("is_global", g.glob, e.glob);
               if (g.hidx !== e.hidx) report("hit_index", g.hidx, e.hidx);
               if (g.ehi !== e.ehi) report("read_entry_hi", g.ehi, e.ehi);
               if (g.rpm !== e.rpm) report("read_pg_mask", g.rpm, e.rpm);
               if (g.rlo0 !== e.rlo0) report("read_lo_even", g.rlo0, e.rlo0);
               if (g.rlo1 !== e.rlo1) report("read_lo_odd", g.rlo1, e.rlo1);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic tlb_req_type mk(logic [2:0] c, logic [31:0] va, logic [7:0] asid,
                                      logic wr, logic [4:0] idx, logic [31:0] pm,
                                      logic [31:0] lo0, logic [31:0] lo1);
      tlb_req_type r;
      r.cmd = c; r.va = va; r.asid = asid; r.wr = wr; r.idx = idx;
      r.pm = pm; r.lo0 = lo0; r.lo1 = lo1;
      return r;
   endfunction

   // Random item; most work on a small set of addresses so translates and probes hit.
   function automatic tlb_req_type rand_item();
      logic [31:0] va, pm;
      int k;
      k = $urandom_range(99);
      va = (k < 80) ? (32'($urandom_range(7)) << 13) | ($urandom & 32'h1FFF)
                    | ($urandom_range(1) ? 32'hFFFF0000 : 32'd0)
                    : $urandom;
      case ($urandom_range(3))
         0: pm = 32'd0;
         1: pm = 32'h0000_6000;
         2: pm = 32'h01FF_E000;
         default: pm = $urandom;
      endcase
      return mk((k < 97) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5)), va,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2)),
                1'($urandom_range(1)), 5'($urandom), pm, $urandom, $urandom);
   endfunction

   task automatic wait_drained();
      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_type i, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      case (i)
         CSR_PAGE_SHIFT: cfg_shift = v[3:0];
         CSR_PHYS_MASK: cfg_pmask = v;
         default: cfg_wired = v[4:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int ph, n;
      for (int i = 0; i < ENTRIES; i++) begin
         m_vpn2[i] = 0; m_asid[i] = 0; m_mask[i] = 0; m_flags[i] = 0;
         m_pfn0[i] = 0; m_pfn1[i] = 0;
      end
      m_rand = ENTRIES - 1;
      cfg_shift = 12; cfg_pmask = 32'hFFFF_FFFF; cfg_wired = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, every command, unknown codes.
      pending_q.push_back(mk(CMD_TRANSLATE, 32'd0, 8'd0, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_WRITE_INDEX, 32'h0000_2000, 8'h05, 1'b0, 5'd0, 0,
                             32'h3FFF_FFC6, 32'h0000_0042));
      pending_q.push_back(mk(CMD_TRANSLATE, 32'h0000_2ABC, 8'h05, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_TRANSLATE, 32'h0000_3ABC, 8'h05, 1'b1, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_TRANSLATE, 32'h0000_2ABC, 8'h06, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_WRITE_INDEX, 32'hFFFF_FFFF, 8'hFF, 1'b1, 5'd31,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_q.push_back(mk(CMD_TRANSLATE, 32'hFFFF_FFFF, 8'h00, 1'b1, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_PROBE, 32'h0000_2000, 8'h05, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_PROBE, 32'h1234_5678, 8'h77, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_READ, 0, 8'd0, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_READ, 0, 8'd0, 1'b0, 5'd31, 0, 0, 0));
      pending_q.push_back(mk(CMD_WRITE_RAND, 32'h0001_0000, 8'h01, 1'b0, 5'd0, 32'h6000,
                             32'h0000_1003, 32'h0000_2007));
      pending_q.push_back(mk(3'd5, 32'hFFFF_FFFF, 8'hFF, 1'b1, 5'd31, '1, '1, '1));
      pending_q.push_back(mk(3'd7, 0, 8'd0, 1'b0, 5'd0, 0, 0, 0));
      pending_q.push_back(mk(CMD_READ, 0, 8'd0, 1'b0, 5'd31, 0, 0, 0));
      wait_drained();

      // Phases across register settings; page shift takes values outside 10..12 too.
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_csr(CSR_PAGE_SHIFT, 10); write_csr(CSR_WIRED, 31); end
            1: begin write_csr(CSR_PHYS_MASK, 32'h0); write_csr(CSR_WIRED, 4); end
            2: begin write_csr(CSR_PAGE_SHIFT, 11); write_csr(CSR_PHYS_MASK, $urandom); end
            3: begin write_csr(CSR_PAGE_SHIFT, 15); write_csr(CSR_PHYS_MASK, '1); end
            4: begin write_csr(CSR_PAGE_SHIFT, 0); write_csr(CSR_WIRED, 0); end
            5: write_csr(CSR_WIRED, $urandom_range(31));
            6: write_csr(CSR_PAGE_SHIFT, 12);
            default: write_csr(CSR_PHYS_MASK, 32'h1FFF_FFFF);
         endcase
         calm = (ph == 6);
         n = 210;
         for (int j = 0; j < n; j++) begin
            pending_q.push_back(rand_item());
            if (j == 100 && ph == 3) begin
               // Let the sender wait until every outstanding result has arrived.
               while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: mips_tlb_translate_and_maintain_top.f
hdl/mtlb_pkg.sv
hdl/mtlb_ctrl.sv
hdl/mtlb_dp.sv
hdl/mips_tlb_translate_and_maintain_top.sv
sim/tb.sv
